### rtl/tslr_pkg.sv
// ----------------------------------------------------------------------------
// tslr_pkg
// Shared types and constants for the tenth-step line rasterizer.
// ----------------------------------------------------------------------------
package tslr_pkg;

  // Field widths of the stream items
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int COLOR_W = 8;
  localparam int ADDR_W  = 16;

  // Packed stream widths (tdata filled up to whole bytes)
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  // Frame buffer row pitch in bytes
  localparam int SCREEN_COLS = 320;

  // Default sub-steps per column and the largest supported value
  localparam int SUB_STEPS_DEF = 10;
  localparam int SUB_STEPS_MAX = 16;

  // Write count of a line: up to SUB_STEPS_MAX * 511
  localparam int SPAN_W  = $clog2(SUB_STEPS_MAX * ((1 << X_W) - 1) + 1);
  // Signed whole part of the slope
  localparam int WHOLE_W = Y_W + 2;

  // Slope divider: one quotient bit per cycle
  localparam int DIV_CNT_W = $clog2(Y_W);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_t;

  // Classified command as it sits in the queue
  typedef struct packed {
    opcode_t              op;
    logic                 vertical;
    logic [X_W-1:0]       col_start;
    logic [Y_W-1:0]       row_start;
    logic [SPAN_W-1:0]    span;
    logic [Y_W-1:0]       dy_mag;
    logic                 dy_neg;
    logic [COLOR_W-1:0]   color;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

  typedef struct packed {
    logic dividing;
    logic active;
    logic emit_last;
  } bk_status_t;

endpackage

### rtl/tslr_front.sv
// ----------------------------------------------------------------------------
// tslr_front
// Accepts stream items, orders line endpoints and sizes the walk.
// ----------------------------------------------------------------------------
module tslr_front import tslr_pkg::*; #(
  parameter int SUB_STEPS = SUB_STEPS_DEF
) (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  q_status_t            q_stat,
  output logic                 push,
  output cmd_t                 cmd
);

  logic [X_W-1:0]     xa, xb, dx;
  logic [Y_W-1:0]     ya, yb, y_lo_x, y_hi_x, y_min, y_max;
  logic [COLOR_W-1:0] color;
  logic               vert, a_first;

  assign xa    = s_tdata[0 +: X_W];
  assign ya    = s_tdata[X_W +: Y_W];
  assign xb    = s_tdata[X_W + Y_W +: X_W];
  assign yb    = s_tdata[2*X_W + Y_W +: Y_W];
  assign color = s_tdata[2*X_W + 2*Y_W +: COLOR_W];

  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && !q_stat.full;

  always_comb begin
    vert    = (xa == xb);
    a_first = (xa < xb);
    dx      = a_first ? (xb - xa) : (xa - xb);
    y_lo_x  = a_first ? ya : yb;
    y_hi_x  = a_first ? yb : ya;
    y_min   = (ya < yb) ? ya : yb;
    y_max   = (ya < yb) ? yb : ya;

    cmd.op    = opcode_t'(s_tuser);
    cmd.color = color;
    cmd.vertical = vert;
    if (vert) begin
      cmd.col_start = xa;
      cmd.row_start = y_min;
      cmd.span      = SPAN_W'(y_max - y_min);
      cmd.dy_mag    = '0;
      cmd.dy_neg    = 1'b0;
    end else begin
      cmd.col_start = a_first ? xa : xb;
      cmd.row_start = y_lo_x;
      cmd.span      = SPAN_W'(dx * SUB_STEPS);
      cmd.dy_neg    = (y_hi_x < y_lo_x);
      cmd.dy_mag    = (y_hi_x < y_lo_x) ? (y_lo_x - y_hi_x) : (y_hi_x - y_lo_x);
    end
  end

endmodule

### rtl/tslr_queue.sv
// ----------------------------------------------------------------------------
// tslr_queue
// Short command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module tslr_queue import tslr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      cmd_in,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign stat.full     = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.nonempty = (count != '0);
  assign head          = entries[rd_ptr];
  assign do_pop        = pop && stat.nonempty;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/tslr_back.sv
// ----------------------------------------------------------------------------
// tslr_back
// Runs loads (slope division for non-vertical lines) and steps (pixel writes) from the queue.
// ----------------------------------------------------------------------------
module tslr_back import tslr_pkg::*; #(
  parameter int SUB_STEPS = SUB_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  head,
  input  q_status_t             q_stat,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  output bk_status_t            status
);

  localparam int TENTH_W = (SUB_STEPS > 1) ? $clog2(SUB_STEPS) : 1;
  localparam logic [TENTH_W-1:0] TENTH_LAST = TENTH_W'(SUB_STEPS - 1);

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_DIV = 3'b010,
    ST_FIN = 3'b100
  } state_t;

  state_t state, state_next;

  // Line state
  logic                active, active_next;
  logic                vertical;
  logic [SPAN_W-1:0]   sub_step, sub_end;
  logic [X_W-1:0]      column;
  logic [TENTH_W-1:0]  tenths;
  logic [Y_W-1:0]      row;
  logic [SPAN_W-1:0]   row_rem;
  logic [WHOLE_W-1:0]  slope_whole;
  logic [SPAN_W-1:0]   slope_rem;
  logic [COLOR_W-1:0]  line_color;

  // Divider state
  logic [SPAN_W-1:0]    div_rem;
  logic [Y_W-1:0]       div_q;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_neg;

  // Output register
  logic [ADDR_W-1:0]  out_addr;
  logic [COLOR_W-1:0] out_color;

  logic               out_free, take, is_load, emit, fin, carry, ge, r_nz;
  logic [SPAN_W:0]    rem_sum, trial;
  logic [ADDR_W-1:0]  addr;
  logic [WHOLE_W-1:0] whole_fin;
  logic [SPAN_W-1:0]  srem_fin;

  assign m_tdata = {out_color, out_addr};

  always_comb begin
    out_free = !m_tvalid || m_tready;
    take     = (state == ST_RUN) && q_stat.nonempty &&
               ((head.op == OP_LOAD) || out_free);
    is_load  = take && (head.op == OP_LOAD);
    emit     = take && (head.op == OP_STEP) && active;
    fin      = ({1'b0, sub_step} + 1'b1) >= {1'b0, sub_end};

    addr = ({{(ADDR_W - Y_W){1'b0}}, row} * ADDR_W'(SCREEN_COLS)) + ADDR_W'(column);

    rem_sum = {1'b0, row_rem} + {1'b0, slope_rem};
    carry   = rem_sum >= {1'b0, sub_end};

    // One restoring step: bring down the next dividend bit
    trial = {div_rem, div_q[Y_W-1]};
    ge    = trial >= {1'b0, sub_end};

    // Floor the quotient for a falling line
    r_nz = (div_rem != '0);
    if (div_neg) begin
      whole_fin = WHOLE_W'(0) - {{(WHOLE_W - Y_W){1'b0}}, div_q} - WHOLE_W'(r_nz);
      srem_fin  = r_nz ? (sub_end - div_rem) : '0;
    end else begin
      whole_fin = {{(WHOLE_W - Y_W){1'b0}}, div_q};
      srem_fin  = div_rem;
    end

    state_next  = state;
    active_next = active;
    case (state)
      ST_RUN: begin
        if (is_load) begin
          if (head.vertical) begin
            active_next = (head.span != '0);
          end else begin
            active_next = 1'b0;
            state_next  = ST_DIV;
          end
        end else if (emit && fin) begin
          active_next = 1'b0;
        end
      end
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        active_next = 1'b1;
        state_next  = ST_RUN;
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  assign pop = take;

  assign status.dividing  = (state != ST_RUN);
  assign status.active    = active;
  assign status.emit_last = emit && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_RUN;
      active   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      active <= active_next;
      if (out_free) begin
        m_tvalid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_addr  <= addr;
      out_color <= line_color;
      m_tlast   <= fin;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_RUN: begin
        if (is_load) begin
          line_color <= head.color;
          sub_step   <= '0;
          tenths     <= '0;
          row_rem    <= '0;
          vertical   <= head.vertical;
          column     <= head.col_start;
          row        <= head.row_start;
          sub_end    <= head.span;
          slope_whole <= '0;
          slope_rem   <= '0;
          div_rem    <= '0;
          div_q      <= head.dy_mag;
          div_neg    <= head.dy_neg;
          div_cnt    <= DIV_CNT_W'(Y_W - 1);
        end else if (emit) begin
          sub_step <= sub_step + 1'b1;
          if (vertical) begin
            row <= row + 1'b1;
          end else begin
            if (tenths == TENTH_LAST) begin
              tenths <= '0;
              column <= column + 1'b1;
            end else begin
              tenths <= tenths + 1'b1;
            end
            row     <= row + slope_whole[Y_W-1:0] + Y_W'(carry);
            row_rem <= carry ? SPAN_W'(rem_sum - {1'b0, sub_end}) : rem_sum[SPAN_W-1:0];
          end
        end
      end
      ST_DIV: begin
        div_rem <= ge ? SPAN_W'(trial - {1'b0, sub_end}) : trial[SPAN_W-1:0];
        div_q   <= {div_q[Y_W-2:0], ge};
        div_cnt <= div_cnt - 1'b1;
      end
      ST_FIN: begin
        slope_whole <= whole_fin;
        slope_rem   <= srem_fin;
      end
      default: begin
        div_cnt <= '0;
      end
    endcase
  end

endmodule

### rtl/tenth_step_line_rasterizer.sv
// A step item's pixel write passes through the command queue and then the
//   output register; steps run back to back at one write per cycle while the
//   output is not stalled and no load is running. A vertical line's load ends
//   when taken; other loads then run the bit-serial divider and a final state.
// Reset (rst, synchronous, active high) empties the queue and the output
//   register and leaves no line active.
// ----------------------------------------------------------------------------
// tenth_step_line_rasterizer
// Line rasterizer walking x in sub-column steps with an exact row quotient.
// ----------------------------------------------------------------------------
module tenth_step_line_rasterizer import tslr_pkg::*; #(
  parameter int SUB_STEPS = SUB_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // x_a[8:0], y_a[16:9], x_b[25:17], y_b[33:26], color[41:34], zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // opcode: 0 load a line, 1 request the next pixel write
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pixel_address[15:0], pixel_color[23:16]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  // Front classifies each item: endpoint order, write count, slope sign and
  // magnitude. The queue lets the back finish a slope division while new
  // items keep arriving.
  q_status_t  q_stat;
  bk_status_t bk_stat;
  cmd_t       push_cmd, head_cmd;
  logic       push, pop;

  tslr_front #(
    .SUB_STEPS (SUB_STEPS)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .push     (push),
    .cmd      (push_cmd)
  );

  tslr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .cmd_in (push_cmd),
    .pop    (pop),
    .head   (head_cmd),
    .stat   (q_stat)
  );

  // Back walks the line: advance column tenths, add the split slope to the
  // row and carry the remainder; drop steps that arrive with no line active.
  tslr_back #(
    .SUB_STEPS (SUB_STEPS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head_cmd),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .status   (bk_stat)
  );

  // Out of reset: nothing to deliver and room to accept
  a_reset_clean: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("block not idle after reset");

  // No new write appears while the slope divider runs
  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (bk_stat.dividing && !m_tvalid) |=> !m_tvalid)
    else $error("write emitted during slope division");

  // The final write of a line ends the line
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    bk_stat.emit_last |=> !bk_stat.active)
    else $error("line still active after final write");

endmodule
